@@ src/bdq_pkg.sv @@
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = PTR_W + 1;
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_SCAN_START,
        OP_SCAN_READ
    } dp_op_t;

    typedef struct packed {
        logic                load_in;
        dp_op_t              op;
        logic                set_result;
        logic [STATUS_W-1:0] result_status;
        logic                result_pop;
        logic                set_found;
        logic                load_out;
    } bdq_ctrl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             empty;
        logic             scan_hit;
        logic             scan_more;
    } bdq_stat_t;

    // Ring index of the entry that sits off places behind the front slot.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] front,
                                                  input logic [SUM_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, front} + off;
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

@@ src/bounded_deque_with_search_unit.sv @@
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  cmd, data_in
// out      output     out_valid / out_stall data_out, found, status, count
//
// One command at a time. Push and pop go from acceptance through EXEC to FIN.
// Find scans in SCAN between EXEC and FIN, one memory read a cycle.
// Find on an empty store skips the scan and goes from EXEC straight to FIN.
// The single read port of the entry store sets the find rate.
// A new command is taken while the previous result still waits on out_stall.
// rst_n clears the pointers and control state; the entry store is not cleared.
module bounded_deque_with_search_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bdq_pkg::CMD_W-1:0]         cmd,
    input  logic signed [bdq_pkg::DATA_W-1:0] data_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bdq_pkg::DATA_W-1:0] data_out,
    output logic                              found,
    output logic [bdq_pkg::STATUS_W-1:0]      status,
    output logic [bdq_pkg::COUNT_W-1:0]       count
);
    import bdq_pkg::*;

    bdq_ctrl_t ctrl;
    bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    bdq_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .stat     (stat),
        .cmd      (cmd),
        .data_in  (data_in),
        .data_out (data_out),
        .found    (found),
        .status   (status),
        .count    (count)
    );

endmodule

@@ src/bdq_dp.sv @@
module bdq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bdq_pkg::bdq_ctrl_t            ctrl,
    output bdq_pkg::bdq_stat_t            stat,
    input  logic [bdq_pkg::CMD_W-1:0]     cmd,
    input  logic signed [bdq_pkg::DATA_W-1:0] data_in,
    output logic signed [bdq_pkg::DATA_W-1:0] data_out,
    output logic                          found,
    output logic [bdq_pkg::STATUS_W-1:0]  status,
    output logic [bdq_pkg::COUNT_W-1:0]   count
);
    import bdq_pkg::*;

    logic [DATA_W-1:0]   mem [CAPACITY];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [PTR_W-1:0]    front_reg;
    logic [PTR_W-1:0]    front_next;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic                cmp_pending_reg;
    logic                cmp_pending_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_pop_reg;
    logic                res_found_reg;
    logic [DATA_W-1:0]   data_out_reg;
    logic                found_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] front_inc;
    logic [PTR_W-1:0] back_addr;
    logic [PTR_W-1:0] last_addr;
    logic [PTR_W-1:0] scan_addr;

    assign front_dec = (front_reg == '0) ? PTR_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PTR_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;
    assign back_addr = wrap_add(front_reg, SUM_W'(fill_reg));
    assign last_addr = wrap_add(front_reg, SUM_W'(fill_reg - 1'b1));
    assign scan_addr = wrap_add(front_reg, SUM_W'(idx_reg));

    assign stat.cmd       = cmd_reg;
    assign stat.full      = (fill_reg == CNT_W'(CAPACITY));
    assign stat.empty     = (fill_reg == '0);
    assign stat.scan_more = (idx_reg < fill_reg);
    assign stat.scan_hit  = cmp_pending_reg && (rd_data_reg == val_reg);

    always_comb
    begin
        front_next       = front_reg;
        fill_next        = fill_reg;
        idx_next         = idx_reg;
        cmp_pending_next = cmp_pending_reg;
        case (ctrl.op)
            OP_PUSH_FRONT:
            begin
                front_next = front_dec;
                fill_next  = fill_reg + 1'b1;
            end
            OP_PUSH_BACK:
            begin
                fill_next = fill_reg + 1'b1;
            end
            OP_POP_FRONT:
            begin
                front_next = front_inc;
                fill_next  = fill_reg - 1'b1;
            end
            OP_POP_BACK:
            begin
                fill_next = fill_reg - 1'b1;
            end
            OP_SCAN_START:
            begin
                idx_next         = '0;
                cmp_pending_next = 1'b0;
            end
            OP_SCAN_READ:
            begin
                idx_next         = idx_reg + 1'b1;
                cmp_pending_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg       <= '0;
            fill_reg        <= '0;
            idx_reg         <= '0;
            cmp_pending_reg <= 1'b0;
        end
        else
        begin
            front_reg       <= front_next;
            fill_reg        <= fill_next;
            idx_reg         <= idx_next;
            cmp_pending_reg <= cmp_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_PUSH_FRONT: mem[front_dec] <= val_reg;
            OP_PUSH_BACK:  mem[back_addr] <= val_reg;
            OP_POP_FRONT:  rd_data_reg    <= mem[front_reg];
            OP_POP_BACK:   rd_data_reg    <= mem[last_addr];
            OP_SCAN_READ:  rd_data_reg    <= mem[scan_addr];
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg <= cmd;
            val_reg <= data_in;
        end
        if (ctrl.set_result)
        begin
            res_status_reg <= ctrl.result_status;
            res_pop_reg    <= ctrl.result_pop;
            res_found_reg  <= 1'b0;
        end
        else if (ctrl.set_found)
        begin
            res_found_reg <= 1'b1;
        end
        if (ctrl.load_out)
        begin
            data_out_reg <= res_pop_reg ? rd_data_reg : '0;
            found_reg    <= res_found_reg;
            status_reg   <= res_status_reg;
            count_reg    <= COUNT_W'(fill_reg);
        end
    end

    assign data_out = data_out_reg;
    assign found    = found_reg;
    assign status   = status_reg;
    assign count    = count_reg;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(CAPACITY))
        else $error("fill count exceeds capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= PTR_W'(CAPACITY - 1))
        else $error("front pointer out of range");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_POP_FRONT || ctrl.op == OP_POP_BACK) |-> fill_reg != '0)
        else $error("pop issued on an empty store");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_PUSH_FRONT || ctrl.op == OP_PUSH_BACK) |=> fill_reg != '0)
        else $error("push left the store empty");
`endif

endmodule

@@ src/bdq_ctrl.sv @@
module bdq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  bdq_pkg::bdq_stat_t stat,
    output bdq_pkg::bdq_ctrl_t ctrl
);
    import bdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;
    logic   accept;

    assign accept = in_valid && !in_stall_reg;

    always_comb
    begin
        ctrl               = '0;
        ctrl.op            = OP_NONE;
        ctrl.result_status = ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.load_in = accept;
            end
            S_EXEC:
            begin
                ctrl.set_result = 1'b1;
                case (stat.cmd)
                    CMD_PUSH_FRONT:
                    begin
                        if (stat.full)
                        begin
                            ctrl.result_status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op = OP_PUSH_FRONT;
                        end
                    end
                    CMD_PUSH_BACK:
                    begin
                        if (stat.full)
                        begin
                            ctrl.result_status = ST_FULL;
                        end
                        else
                        begin
                            ctrl.op = OP_PUSH_BACK;
                        end
                    end
                    CMD_POP_FRONT:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.result_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op         = OP_POP_FRONT;
                            ctrl.result_pop = 1'b1;
                        end
                    end
                    CMD_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            ctrl.result_status = ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.op         = OP_POP_BACK;
                            ctrl.result_pop = 1'b1;
                        end
                    end
                    CMD_FIND:
                    begin
                        if (!stat.empty)
                        begin
                            ctrl.op = OP_SCAN_START;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                begin
                    ctrl.set_found = 1'b1;
                end
                else if (stat.scan_more)
                begin
                    ctrl.op = OP_SCAN_READ;
                end
            end
            S_FIN:
            begin
                ctrl.load_out = !out_valid_reg || !out_stall;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg    <= S_EXEC;
                        in_stall_reg <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    if (stat.cmd == CMD_FIND && !stat.empty)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_SCAN:
                begin
                    if (stat.scan_hit || !stat.scan_more)
                    begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (ctrl.load_out)
                    begin
                        state_reg    <= S_IDLE;
                        in_stall_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall_reg)
        else $error("input not stalled while a transaction is in progress");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_EXEC)
        else $error("accepted transaction did not start execution");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result load did not raise out_valid");
`endif

endmodule
